// ===== rtl/core/harp_pkg.sv =====
// ----------------------------------------------------------------------------
// harp_pkg
// Shared types, codes and helpers for the hex archive record parser.
// ----------------------------------------------------------------------------
package harp_pkg;

    localparam int SIZE_BITS_DEF = 32;
    localparam int PERM_BITS_DEF = 12;

    localparam int PERM_OUT_W  = 12;
    localparam int COUNT_OUT_W = 32;
    localparam int FIFO_DEPTH  = 4;

    localparam logic [7:0] CHAR_NL   = 8'h0A;
    localparam logic [7:0] CHAR_DOT  = 8'h2E;
    localparam logic [7:0] CHAR_0    = 8'h30;
    localparam logic [7:0] CHAR_7    = 8'h37;
    localparam logic [7:0] CHAR_9    = 8'h39;
    localparam logic [7:0] CHAR_UA   = 8'h41;
    localparam logic [7:0] CHAR_UF   = 8'h46;
    localparam logic [7:0] CHAR_LA   = 8'h61;
    localparam logic [7:0] CHAR_LF   = 8'h66;

    typedef enum logic [1:0] {
        PH_PERM = 2'd0,
        PH_NAME = 2'd1,
        PH_SIZE = 2'd2,
        PH_DATA = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        KIND_PERMISSION = 3'd0,
        KIND_NAME_CHAR  = 3'd1,
        KIND_HEADER     = 3'd2,
        KIND_DATA_BYTE  = 3'd3,
        KIND_RECORD_END = 3'd4,
        KIND_ERROR      = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NO_NEWLINE = 3'd0,
        ERR_BAD_NUMBER = 3'd1,
        ERR_ODD_HEX    = 3'd2,
        ERR_BAD_DIGIT  = 3'd3,
        ERR_MISMATCH   = 3'd4,
        ERR_EARLY_END  = 3'd5,
        ERR_DOTDOT     = 3'd6,
        ERR_OVERFLOW   = 3'd7
    } err_t;

    typedef struct packed {
        logic [2:0]             kind;
        logic [7:0]             byte_value;
        logic [PERM_OUT_W-1:0]  permission;
        logic [COUNT_OUT_W-1:0] byte_count;
        logic [2:0]             error_code;
        logic                   last;
    } result_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t d;
        d.valid = 1'b1;
        d.value = c[3:0];
        if (c >= CHAR_0 && c <= CHAR_9)
        begin
            d.value = c[3:0];
        end
        else if ((c >= CHAR_UA && c <= CHAR_UF) || (c >= CHAR_LA && c <= CHAR_LF))
        begin
            d.value = 4'(c[2:0] + 3'd1) + 4'd8;
        end
        else
        begin
            d.valid = 1'b0;
        end
        return d;
    endfunction

    function automatic result_t mk_res(
        input kind_t                  kind,
        input logic [7:0]             byte_value,
        input logic [PERM_OUT_W-1:0]  permission,
        input logic [COUNT_OUT_W-1:0] byte_count,
        input err_t                   error_code
    );
        result_t r;
        r.kind       = kind;
        r.byte_value = byte_value;
        r.permission = permission;
        r.byte_count = byte_count;
        r.error_code = error_code;
        r.last       = 1'b0;
        return r;
    endfunction

endpackage

// ===== rtl/core/harp_in_if.sv =====
// ----------------------------------------------------------------------------
// harp_in_if
// Character channel into the archive parser.
// ----------------------------------------------------------------------------
interface harp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_of_archive;

    modport source (output valid, output ch, output end_of_archive, input ready);
    modport sink   (input valid, input ch, input end_of_archive, output ready);
endinterface

// ===== rtl/core/harp_out_if.sv =====
// ----------------------------------------------------------------------------
// harp_out_if
// Result channel out of the archive parser.
// ----------------------------------------------------------------------------
interface harp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  byte_value;
    logic [11:0] permission;
    logic [31:0] byte_count;
    logic [2:0]  error_code;
    logic        last;

    modport source (output valid, output kind, output byte_value, output permission,
                    output byte_count, output error_code, output last, input ready);
    modport sink   (input valid, input kind, input byte_value, input permission,
                    input byte_count, input error_code, input last, output ready);
endinterface

// ===== rtl/core/hex_archive_record_parser_top.sv =====
// ----------------------------------------------------------------------------
// hex_archive_record_parser_top
// Parses an archive one character per transaction and emits record results.
// A result is written into the result queue when its character is accepted.
// Throughput: one character per cycle while input ready is high; a character
// that yields two results writes both into the four-entry result queue.
// Input ready is high while the queue has room for two results.
// Reset clears the parser state and the queue; after an error the block
// discards characters until the next reset.
// ----------------------------------------------------------------------------
module hex_archive_record_parser_top #(
    parameter int SIZE_BITS = harp_pkg::SIZE_BITS_DEF,
    parameter int PERM_BITS = harp_pkg::PERM_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    harp_in_if.sink         chars,
    harp_out_if.source      results
);

    localparam int PW = (PERM_BITS > harp_pkg::PERM_OUT_W) ? PERM_BITS : harp_pkg::PERM_OUT_W;
    localparam int CW = (SIZE_BITS > harp_pkg::COUNT_OUT_W) ? SIZE_BITS
                                                            : harp_pkg::COUNT_OUT_W;
    localparam int HB = SIZE_BITS + 1;
    localparam int PTR_W = $clog2(harp_pkg::FIFO_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    harp_pkg::phase_t     phase_reg, phase_next;
    logic [PERM_BITS-1:0] perm_accum_reg, perm_accum_next;
    logic [SIZE_BITS-1:0] size_accum_reg, size_accum_next;
    logic [HB-1:0]        hex_remaining_reg, hex_remaining_next;
    logic [3:0]           high_nibble_reg, high_nibble_next;
    logic                 nibble_pending_reg, nibble_pending_next;
    logic                 digit_seen_reg, digit_seen_next;
    logic                 prev_dot_reg, prev_dot_next;
    logic                 dotdot_seen_reg, dotdot_seen_next;
    logic                 halted_reg, halted_next;

    harp_pkg::result_t    fifo_reg [harp_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;

    logic                 in_fire;
    logic                 out_fire;
    logic [PERM_BITS+2:0] perm_nv;
    logic [SIZE_BITS+3:0] size_nv;
    logic [PW-1:0]        perm_ext;
    logic [CW-1:0]        count_ext;
    harp_pkg::hex_digit_t hd;
    logic                 prim_v, fin_v, eoa_v, fin_check;
    harp_pkg::result_t    prim, fin, eoa_r, slot0, slot1;
    logic [1:0]           n_res;

    assign in_fire  = chars.valid & chars.ready;
    assign out_fire = results.valid & results.ready;
    assign chars.ready = (count_reg <= CNT_W'(harp_pkg::FIFO_DEPTH - 2));

    assign perm_nv = {perm_accum_reg, 3'b000} + (PERM_BITS + 3)'(chars.ch[2:0]);
    assign size_nv = ({4'b0000, size_accum_reg} << 3) + ({4'b0000, size_accum_reg} << 1)
                   + (SIZE_BITS + 4)'(chars.ch[3:0]);
    assign perm_ext  = PW'(perm_accum_reg);
    assign count_ext = CW'(size_accum_reg);
    assign hd = harp_pkg::hex_decode(chars.ch);

    always_comb
    begin
        phase_next          = phase_reg;
        perm_accum_next     = perm_accum_reg;
        size_accum_next     = size_accum_reg;
        hex_remaining_next  = hex_remaining_reg;
        high_nibble_next    = high_nibble_reg;
        nibble_pending_next = nibble_pending_reg;
        digit_seen_next     = digit_seen_reg;
        prev_dot_next       = prev_dot_reg;
        dotdot_seen_next    = dotdot_seen_reg;
        halted_next         = halted_reg;
        prim_v    = 1'b0;
        fin_v     = 1'b0;
        eoa_v     = 1'b0;
        fin_check = 1'b0;
        prim  = '0;
        fin   = '0;
        eoa_r = '0;

        if (!halted_reg)
        begin
            case (phase_reg)
                harp_pkg::PH_PERM:
                begin
                    if (chars.ch == harp_pkg::CHAR_NL)
                    begin
                        prim_v = 1'b1;
                        if (!digit_seen_reg)
                        begin
                            prim = harp_pkg::mk_res(harp_pkg::KIND_ERROR, 8'd0, '0, '0,
                                                    harp_pkg::ERR_BAD_NUMBER);
                        end
                        else
                        begin
                            prim = harp_pkg::mk_res(harp_pkg::KIND_PERMISSION, 8'd0,
                                                    perm_ext[harp_pkg::PERM_OUT_W-1:0], '0,
                                                    harp_pkg::ERR_NO_NEWLINE);
                            phase_next       = harp_pkg::PH_NAME;
                            digit_seen_next  = 1'b0;
                            prev_dot_next    = 1'b0;
                            dotdot_seen_next = 1'b0;
                        end
                    end
                    else if (chars.ch >= harp_pkg::CHAR_0 && chars.ch <= harp_pkg::CHAR_7)
                    begin
                        if (|perm_nv[PERM_BITS+2:PERM_BITS])
                        begin
                            prim_v = 1'b1;
                            prim = harp_pkg::mk_res(harp_pkg::KIND_ERROR, 8'd0, '0, '0,
                                                    harp_pkg::ERR_OVERFLOW);
                        end
                        else
                        begin
                            perm_accum_next = perm_nv[PERM_BITS-1:0];
                            digit_seen_next = 1'b1;
                        end
                    end
                    else
                    begin
                        prim_v = 1'b1;
                        prim = harp_pkg::mk_res(harp_pkg::KIND_ERROR, 8'd0, '0, '0,
                                                harp_pkg::ERR_BAD_NUMBER);
                    end
                end
                harp_pkg::PH_NAME:
                begin
                    if (chars.ch == harp_pkg::CHAR_NL)
                    begin
                        phase_next      = harp_pkg::PH_SIZE;
                        digit_seen_next = 1'b0;
                        size_accum_next = '0;
                    end
                    else
                    begin
                        prim_v = 1'b1;
                        prim = harp_pkg::mk_res(harp_pkg::KIND_NAME_CHAR, chars.ch, '0, '0,
                                                harp_pkg::ERR_NO_NEWLINE);
                        if (chars.ch == harp_pkg::CHAR_DOT)
                        begin
                            if (prev_dot_reg)
                            begin
                                dotdot_seen_next = 1'b1;
                            end
                            prev_dot_next = 1'b1;
                        end
                        else
                        begin
                            prev_dot_next = 1'b0;
                        end
                    end
                end
                harp_pkg::PH_SIZE:
                begin
                    if (chars.ch == harp_pkg::CHAR_NL)
                    begin
                        prim_v = 1'b1;
                        if (!digit_seen_reg)
                        begin
                            prim = harp_pkg::mk_res(harp_pkg::KIND_ERROR, 8'd0, '0, '0,
                                                    harp_pkg::ERR_BAD_NUMBER);
                        end
                        else
                        begin
                            prim = harp_pkg::mk_res(harp_pkg::KIND_HEADER, 8'd0, '0,
                                                    count_ext[harp_pkg::COUNT_OUT_W-1:0],
                                                    harp_pkg::ERR_NO_NEWLINE);
                            hex_remaining_next  = {size_accum_reg, 1'b0};
                            nibble_pending_next = 1'b0;
                            digit_seen_next     = 1'b0;
                            if (size_accum_reg == '0)
                            begin
                                fin_check = 1'b1;
                            end
                            else
                            begin
                                phase_next = harp_pkg::PH_DATA;
                            end
                        end
                    end
                    else if (chars.ch >= harp_pkg::CHAR_0 && chars.ch <= harp_pkg::CHAR_9)
                    begin
                        if (|size_nv[SIZE_BITS+3:SIZE_BITS])
                        begin
                            prim_v = 1'b1;
                            prim = harp_pkg::mk_res(harp_pkg::KIND_ERROR, 8'd0, '0, '0,
                                                    harp_pkg::ERR_OVERFLOW);
                        end
                        else
                        begin
                            size_accum_next = size_nv[SIZE_BITS-1:0];
                            digit_seen_next = 1'b1;
                        end
                    end
                    else
                    begin
                        prim_v = 1'b1;
                        prim = harp_pkg::mk_res(harp_pkg::KIND_ERROR, 8'd0, '0, '0,
                                                harp_pkg::ERR_BAD_NUMBER);
                    end
                end
                default:
                begin
                    if (chars.ch == harp_pkg::CHAR_NL)
                    begin
                        if (nibble_pending_reg)
                        begin
                            prim_v = 1'b1;
                            prim = harp_pkg::mk_res(harp_pkg::KIND_ERROR, 8'd0, '0, '0,
                                                    harp_pkg::ERR_ODD_HEX);
                        end
                        else
                        begin
                            digit_seen_next = 1'b0;
                            fin_check = (hex_remaining_reg == '0);
                        end
                    end
                    else if (!hd.valid)
                    begin
                        prim_v = 1'b1;
                        prim = harp_pkg::mk_res(harp_pkg::KIND_ERROR, 8'd0, '0, '0,
                                                harp_pkg::ERR_BAD_DIGIT);
                    end
                    else if (hex_remaining_reg == '0)
                    begin
                        prim_v = 1'b1;
                        prim = harp_pkg::mk_res(harp_pkg::KIND_ERROR, 8'd0, '0, '0,
                                                harp_pkg::ERR_MISMATCH);
                    end
                    else
                    begin
                        hex_remaining_next = hex_remaining_reg - HB'(1);
                        digit_seen_next    = 1'b1;
                        if (nibble_pending_reg)
                        begin
                            prim_v = 1'b1;
                            prim = harp_pkg::mk_res(harp_pkg::KIND_DATA_BYTE,
                                                    {high_nibble_reg, hd.value}, '0, '0,
                                                    harp_pkg::ERR_NO_NEWLINE);
                            nibble_pending_next = 1'b0;
                        end
                        else
                        begin
                            high_nibble_next    = hd.value;
                            nibble_pending_next = 1'b1;
                        end
                    end
                end
            endcase

            if (fin_check)
            begin
                fin_v = 1'b1;
                if (dotdot_seen_reg)
                begin
                    fin = harp_pkg::mk_res(harp_pkg::KIND_ERROR, 8'd0, '0, '0,
                                           harp_pkg::ERR_DOTDOT);
                end
                else
                begin
                    fin = harp_pkg::mk_res(harp_pkg::KIND_RECORD_END, 8'd0, '0, '0,
                                           harp_pkg::ERR_NO_NEWLINE);
                    phase_next          = harp_pkg::PH_PERM;
                    perm_accum_next     = '0;
                    digit_seen_next     = 1'b0;
                    nibble_pending_next = 1'b0;
                    prev_dot_next       = 1'b0;
                    dotdot_seen_next    = 1'b0;
                end
            end

            halted_next = (prim_v && prim.kind == harp_pkg::KIND_ERROR)
                       || (fin_v && fin.kind == harp_pkg::KIND_ERROR);

            if (!halted_next && chars.end_of_archive)
            begin
                if (phase_next == harp_pkg::PH_PERM && !digit_seen_next)
                begin
                    eoa_v = 1'b0;
                end
                else
                begin
                    eoa_v = 1'b1;
                    halted_next = 1'b1;
                    if (phase_next == harp_pkg::PH_DATA && !digit_seen_next)
                    begin
                        eoa_r = harp_pkg::mk_res(harp_pkg::KIND_ERROR, 8'd0, '0, '0,
                                                 harp_pkg::ERR_EARLY_END);
                    end
                    else
                    begin
                        eoa_r = harp_pkg::mk_res(harp_pkg::KIND_ERROR, 8'd0, '0, '0,
                                                 harp_pkg::ERR_NO_NEWLINE);
                    end
                end
            end
        end
    end

    // At most two of the three candidates are ever raised together.
    always_comb
    begin
        n_res = 2'(prim_v) + 2'(fin_v) + 2'(eoa_v);
        if (prim_v)
        begin
            slot0 = prim;
            slot1 = fin_v ? fin : eoa_r;
        end
        else
        begin
            slot0 = fin_v ? fin : eoa_r;
            slot1 = eoa_r;
        end
        slot0.last = (n_res == 2'd1);
        slot1.last = 1'b1;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (in_fire)
        begin
            wr_ptr_next = wr_ptr_reg + PTR_W'(n_res);
            count_next  = count_next + CNT_W'(n_res);
        end
        if (out_fire)
        begin
            rd_ptr_next = rd_ptr_reg + PTR_W'(1);
            count_next  = count_next - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= harp_pkg::PH_PERM;
            perm_accum_reg     <= '0;
            size_accum_reg     <= '0;
            hex_remaining_reg  <= '0;
            high_nibble_reg    <= '0;
            nibble_pending_reg <= 1'b0;
            digit_seen_reg     <= 1'b0;
            prev_dot_reg       <= 1'b0;
            dotdot_seen_reg    <= 1'b0;
            halted_reg         <= 1'b0;
            wr_ptr_reg         <= '0;
            rd_ptr_reg         <= '0;
            count_reg          <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                phase_reg          <= phase_next;
                perm_accum_reg     <= perm_accum_next;
                size_accum_reg     <= size_accum_next;
                hex_remaining_reg  <= hex_remaining_next;
                high_nibble_reg    <= high_nibble_next;
                nibble_pending_reg <= nibble_pending_next;
                digit_seen_reg     <= digit_seen_next;
                prev_dot_reg       <= prev_dot_next;
                dotdot_seen_reg    <= dotdot_seen_next;
                halted_reg         <= halted_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && n_res != 2'd0)
        begin
            fifo_reg[wr_ptr_reg] <= slot0;
        end
        if (in_fire && n_res == 2'd2)
        begin
            fifo_reg[wr_ptr_reg + PTR_W'(1)] <= slot1;
        end
    end

    assign results.valid      = (count_reg != '0);
    assign results.kind       = fifo_reg[rd_ptr_reg].kind;
    assign results.byte_value = fifo_reg[rd_ptr_reg].byte_value;
    assign results.permission = fifo_reg[rd_ptr_reg].permission;
    assign results.byte_count = fifo_reg[rd_ptr_reg].byte_count;
    assign results.error_code = fifo_reg[rd_ptr_reg].error_code;
    assign results.last       = fifo_reg[rd_ptr_reg].last;

endmodule

// ===== rtl/core/harp_checker.sv =====
// ----------------------------------------------------------------------------
// harp_checker
// Port-level checks on the archive parser's result stream.
// ----------------------------------------------------------------------------
module harp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] out_kind,
    input logic [2:0] out_error_code,
    input logic       out_last
);

    // A stalled result transaction keeps its valid and its kind.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_kind))
        else $error("result changed while stalled");

    // An error is always the final result of its character.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == harp_pkg::KIND_ERROR |-> out_last)
        else $error("error result without last");

    // Once an error has been delivered, the parser stays silent.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_kind == harp_pkg::KIND_ERROR |=> !out_valid)
        else $error("result after error");

    // Only error results carry a nonzero error code.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind != harp_pkg::KIND_ERROR |-> out_error_code == 3'd0)
        else $error("error code on non-error result");

endmodule

bind hex_archive_record_parser_top harp_checker u_harp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (results.valid),
    .out_ready      (results.ready),
    .out_kind       (results.kind),
    .out_error_code (results.error_code),
    .out_last       (results.last)
);

// ===== test/harp_result_checker.sv =====
// ----------------------------------------------------------------------------
// harp_result_checker
// Watches the character and result channels of the archive parser. Each
// accepted character is run through a local model of the parser, and every
// result the block hands out is compared field by field with the oldest
// outstanding prediction.
// ----------------------------------------------------------------------------
module harp_result_checker #(
    parameter int SIZE_BITS = harp_pkg::SIZE_BITS_DEF,
    parameter int PERM_BITS = harp_pkg::PERM_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    harp_in_if   chars,
    harp_out_if  results,
    output int   errors,
    output int   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [67:0] PERM_LIMIT = (68'd1 << PERM_BITS) - 68'd1;
    localparam logic [67:0] SIZE_LIMIT = (68'd1 << SIZE_BITS) - 68'd1;

    harp_pkg::phase_t  phase;
    logic [63:0]       perm_acc;
    logic [63:0]       size_acc;
    logic [63:0]       hex_left;
    logic [3:0]        hi_nib;
    logic              nib_pend;
    logic              dig_seen;
    logic              prev_dot;
    logic              dotdot;
    logic              halted;

    harp_pkg::result_t step_q[$];
    harp_pkg::result_t pending_results[$];
    int                mismatch_count;

    assign errors = mismatch_count;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: MISMATCH %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        if (c >= harp_pkg::CHAR_0 && c <= harp_pkg::CHAR_9)
        begin
            return {1'b1, 4'(c - harp_pkg::CHAR_0)};
        end
        if (c >= harp_pkg::CHAR_UA && c <= harp_pkg::CHAR_UF)
        begin
            return {1'b1, 4'(c - harp_pkg::CHAR_UA + 8'd10)};
        end
        if (c >= harp_pkg::CHAR_LA && c <= harp_pkg::CHAR_LF)
        begin
            return {1'b1, 4'(c - harp_pkg::CHAR_LA + 8'd10)};
        end
        return 5'd0;
    endfunction

    task automatic emit(input harp_pkg::kind_t k, input logic [7:0] b, input logic [63:0] p,
                        input logic [63:0] n, input logic [2:0] e);
        harp_pkg::result_t r;
        r.kind       = k;
        r.byte_value = b;
        r.permission = p[harp_pkg::PERM_OUT_W-1:0];
        r.byte_count = n[harp_pkg::COUNT_OUT_W-1:0];
        r.error_code = e;
        r.last       = 1'b0;
        step_q.push_back(r);
    endtask

    task automatic raise(input harp_pkg::err_t code);
        emit(harp_pkg::KIND_ERROR, '0, '0, '0, code);
        halted = 1'b1;
    endtask

    task automatic finish_record();
        if (dotdot)
        begin
            raise(harp_pkg::ERR_DOTDOT);
            return;
        end
        emit(harp_pkg::KIND_RECORD_END, '0, '0, '0, '0);
        phase    = harp_pkg::PH_PERM;
        perm_acc = '0;
        dig_seen = 1'b0;
        nib_pend = 1'b0;
        prev_dot = 1'b0;
        dotdot   = 1'b0;
    endtask

    task automatic clear_parser();
        phase    = harp_pkg::PH_PERM;
        perm_acc = '0;
        size_acc = '0;
        hex_left = '0;
        hi_nib   = '0;
        nib_pend = 1'b0;
        dig_seen = 1'b0;
        prev_dot = 1'b0;
        dotdot   = 1'b0;
        halted   = 1'b0;
    endtask

    task automatic parse_char(input logic [7:0] c, input logic eoa);
        logic [67:0] nv;
        logic [4:0]  hx;
        step_q.delete();
        if (halted)
        begin
            return;
        end
        case (phase)
            harp_pkg::PH_PERM:
            begin
                if (c == harp_pkg::CHAR_NL)
                begin
                    if (!dig_seen)
                    begin
                        raise(harp_pkg::ERR_BAD_NUMBER);
                    end
                    else
                    begin
                        emit(harp_pkg::KIND_PERMISSION, '0, perm_acc, '0, '0);
                        phase    = harp_pkg::PH_NAME;
                        dig_seen = 1'b0;
                        prev_dot = 1'b0;
                        dotdot   = 1'b0;
                    end
                end
                else if (c >= harp_pkg::CHAR_0 && c <= harp_pkg::CHAR_7)
                begin
                    nv = perm_acc * 8 + (c - harp_pkg::CHAR_0);
                    if (nv > PERM_LIMIT)
                    begin
                        raise(harp_pkg::ERR_OVERFLOW);
                    end
                    else
                    begin
                        perm_acc = nv[63:0];
                        dig_seen = 1'b1;
                    end
                end
                else
                begin
                    raise(harp_pkg::ERR_BAD_NUMBER);
                end
            end
            harp_pkg::PH_NAME:
            begin
                if (c == harp_pkg::CHAR_NL)
                begin
                    phase    = harp_pkg::PH_SIZE;
                    dig_seen = 1'b0;
                    size_acc = '0;
                end
                else
                begin
                    emit(harp_pkg::KIND_NAME_CHAR, c, '0, '0, '0);
                    if (c == harp_pkg::CHAR_DOT)
                    begin
                        if (prev_dot)
                        begin
                            dotdot = 1'b1;
                        end
                        prev_dot = 1'b1;
                    end
                    else
                    begin
                        prev_dot = 1'b0;
                    end
                end
            end
            harp_pkg::PH_SIZE:
            begin
                if (c == harp_pkg::CHAR_NL)
                begin
                    if (!dig_seen)
                    begin
                        raise(harp_pkg::ERR_BAD_NUMBER);
                    end
                    else
                    begin
                        emit(harp_pkg::KIND_HEADER, '0, '0, size_acc, '0);
                        hex_left = size_acc * 2;
                        nib_pend = 1'b0;
                        dig_seen = 1'b0;
                        if (hex_left == 0)
                        begin
                            finish_record();
                        end
                        else
                        begin
                            phase = harp_pkg::PH_DATA;
                        end
                    end
                end
                else if (c >= harp_pkg::CHAR_0 && c <= harp_pkg::CHAR_9)
                begin
                    nv = size_acc * 10 + (c - harp_pkg::CHAR_0);
                    if (nv > SIZE_LIMIT)
                    begin
                        raise(harp_pkg::ERR_OVERFLOW);
                    end
                    else
                    begin
                        size_acc = nv[63:0];
                        dig_seen = 1'b1;
                    end
                end
                else
                begin
                    raise(harp_pkg::ERR_BAD_NUMBER);
                end
            end
            default:
            begin
                if (c == harp_pkg::CHAR_NL)
                begin
                    if (nib_pend)
                    begin
                        raise(harp_pkg::ERR_ODD_HEX);
                    end
                    else
                    begin
                        dig_seen = 1'b0;
                        if (hex_left == 0)
                        begin
                            finish_record();
                        end
                    end
                end
                else
                begin
                    hx = hex_nibble(c);
                    if (!hx[4])
                    begin
                        raise(harp_pkg::ERR_BAD_DIGIT);
                    end
                    else if (hex_left == 0)
                    begin
                        raise(harp_pkg::ERR_MISMATCH);
                    end
                    else
                    begin
                        hex_left = hex_left - 1;
                        dig_seen = 1'b1;
                        if (nib_pend)
                        begin
                            emit(harp_pkg::KIND_DATA_BYTE, {hi_nib, hx[3:0]}, '0, '0, '0);
                            nib_pend = 1'b0;
                        end
                        else
                        begin
                            hi_nib   = hx[3:0];
                            nib_pend = 1'b1;
                        end
                    end
                end
            end
        endcase

        // The end mark is clean only at the start of a permission line.
        if (!halted && eoa && !(phase == harp_pkg::PH_PERM && !dig_seen))
        begin
            if (phase == harp_pkg::PH_DATA && !dig_seen)
            begin
                raise(harp_pkg::ERR_EARLY_END);
            end
            else
            begin
                raise(harp_pkg::ERR_NO_NEWLINE);
            end
        end

        if (step_q.size() > 0)
        begin
            step_q[step_q.size()-1].last = 1'b1;
        end
        pending_results = {pending_results, step_q};
    endtask

    task automatic check_result();
        harp_pkg::result_t want;
        if (pending_results.size() == 0)
        begin
            report_mismatch($sformatf("result of kind %0d arrived with none outstanding",
                                      results.kind));
            return;
        end
        want = pending_results.pop_front();
        if (results.kind !== want.kind)
        begin
            report_mismatch($sformatf("kind %0d, expected %0d", results.kind, want.kind));
        end
        if (results.byte_value !== want.byte_value)
        begin
            report_mismatch($sformatf("byte_value %02h, expected %02h",
                                      results.byte_value, want.byte_value));
        end
        if (results.permission !== want.permission)
        begin
            report_mismatch($sformatf("permission %0o, expected %0o",
                                      results.permission, want.permission));
        end
        if (results.byte_count !== want.byte_count)
        begin
            report_mismatch($sformatf("byte_count %0d, expected %0d",
                                      results.byte_count, want.byte_count));
        end
        if (results.error_code !== want.error_code)
        begin
            report_mismatch($sformatf("error_code %0d, expected %0d",
                                      results.error_code, want.error_code));
        end
        if (results.last !== want.last)
        begin
            report_mismatch($sformatf("last %0b, expected %0b", results.last, want.last));
        end
    endtask

    initial
    begin
        mismatch_count = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_parser();
            pending_results.delete();
            outstanding <= 0;
        end
        else
        begin
            if (chars.valid && chars.ready)
            begin
                parse_char(chars.ch, chars.end_of_archive);
            end
            if (results.valid && results.ready)
            begin
                check_result();
            end
            outstanding <= pending_results.size();
        end
    end

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Feeds the archive parser with well-formed archives of random records under
// random gaps and result back-pressure, then ends with one randomly chosen
// malformed record and a few characters the halted block must ignore. The
// checker beside the block predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS  = 950;
    localparam int TAIL_ITEMS    = 150;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 20;

    logic clk;
    logic rst_n;
    int   errors;
    int   outstanding;
    int   n_sent;
    int   gap_pct;
    int   stall_pct;
    bit   quiet;

    logic [7:0] arch_q[$];

    harp_in_if  chars();
    harp_out_if results();

    hex_archive_record_parser_top uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars),
        .results (results)
    );

    harp_result_checker res_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .chars       (chars),
        .results     (results),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic send_char(input logic [7:0] c, input logic eoa);
        if (!quiet && gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            chars.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        chars.valid          <= 1'b1;
        chars.ch             <= c;
        chars.end_of_archive <= eoa;
        @(posedge clk);
        while (!chars.ready)
        begin
            @(posedge clk);
        end
        n_sent++;
    endtask

    task automatic send_queue(input bit eoa_last);
        for (int i = 0; i < arch_q.size(); i++)
        begin
            send_char(arch_q[i], eoa_last && i == arch_q.size() - 1);
        end
        arch_q.delete();
    endtask

    task automatic drain();
        chars.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            arch_q.push_back(s[i]);
        end
    endtask

    task automatic push_number(input longint unsigned v, input int unsigned radix,
                               input int zeros);
        logic [7:0] digs[$];
        repeat (zeros) arch_q.push_back(harp_pkg::CHAR_0);
        do
        begin
            digs.push_front(8'(harp_pkg::CHAR_0 + v % radix));
            v = v / radix;
        end
        while (v != 0);
        arch_q = {arch_q, digs};
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
        begin
            return harp_pkg::CHAR_0 + 8'(n);
        end
        return ($urandom_range(0, 1) ? harp_pkg::CHAR_UA : harp_pkg::CHAR_LA) + 8'(n) - 8'd10;
    endfunction

    task automatic add_record(input int unsigned perm, input int name_len,
                              input int unsigned size);
        logic [7:0] c;
        logic [7:0] b;
        push_number(perm, 8, $urandom_range(0, 1));
        arch_q.push_back(harp_pkg::CHAR_NL);
        for (int i = 0; i < name_len; i++)
        begin
            c = ($urandom_range(0, 4) == 0) ? harp_pkg::CHAR_DOT : 8'($urandom_range(0, 255));
            if (c == harp_pkg::CHAR_NL
                || (c == harp_pkg::CHAR_DOT && i != 0 && arch_q[$] == harp_pkg::CHAR_DOT))
            begin
                c = 8'($urandom_range(harp_pkg::CHAR_0, harp_pkg::CHAR_9));
            end
            arch_q.push_back(c);
        end
        arch_q.push_back(harp_pkg::CHAR_NL);
        push_number(size, 10, $urandom_range(0, 1));
        arch_q.push_back(harp_pkg::CHAR_NL);
        if (size != 0 && $urandom_range(0, 5) == 0)
        begin
            arch_q.push_back(harp_pkg::CHAR_NL);
        end
        for (int i = 0; i < size; i++)
        begin
            if (i != 0 && $urandom_range(0, 5) == 0)
            begin
                arch_q.push_back(harp_pkg::CHAR_NL);
                if ($urandom_range(0, 3) == 0)
                begin
                    arch_q.push_back(harp_pkg::CHAR_NL);
                end
            end
            b = 8'($urandom_range(0, 255));
            arch_q.push_back(hex_char(b[7:4]));
            arch_q.push_back(hex_char(b[3:0]));
        end
        if (size != 0)
        begin
            arch_q.push_back(harp_pkg::CHAR_NL);
        end
    endtask

    task automatic add_archive();
        int unsigned perm;
        int unsigned size;
        repeat ($urandom_range(1, 5))
        begin
            case ($urandom_range(0, 7))
                0: perm = 0;
                1: perm = 4095;
                default: perm = $urandom_range(0, 4095);
            endcase
            size = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 8) : $urandom_range(9, 40);
            add_record(perm, $urandom_range(0, 8), size);
        end
    endtask

    task automatic send_broken_record();
        harp_pkg::err_t pick;
        pick = harp_pkg::err_t'($urandom_range(0, 7));
        case (pick)
            harp_pkg::ERR_NO_NEWLINE:
            begin
                push_text("644\nabc");
                send_queue(1'b1);
            end
            harp_pkg::ERR_BAD_NUMBER:
            begin
                case ($urandom_range(0, 2))
                    0: push_text("\n");
                    1: push_text("648\n");
                    default: push_text("644\nx\n-1\n");
                endcase
                send_queue(1'b0);
            end
            harp_pkg::ERR_ODD_HEX:
            begin
                push_text("600\nodd\n2\nabc\n");
                send_queue(1'b0);
            end
            harp_pkg::ERR_BAD_DIGIT:
            begin
                push_text("600\nbad\n2\n0g12\n");
                send_queue(1'b0);
            end
            harp_pkg::ERR_MISMATCH:
            begin
                push_text("600\nlong\n1\n0a1\n");
                send_queue(1'b0);
            end
            harp_pkg::ERR_EARLY_END:
            begin
                if ($urandom_range(0, 1))
                begin
                    push_text("600\nbig\n4294967295\n");
                end
                else
                begin
                    push_text("600\nshort\n3\n0102\n");
                end
                send_queue(1'b1);
            end
            harp_pkg::ERR_DOTDOT:
            begin
                if ($urandom_range(0, 1))
                begin
                    push_text("600\na..b\n0\n");
                end
                else
                begin
                    push_text("600\n..\n1\nff\n");
                end
                send_queue(1'b0);
            end
            harp_pkg::ERR_OVERFLOW:
            begin
                if ($urandom_range(0, 1))
                begin
                    push_text("10000\n");
                end
                else
                begin
                    push_text("600\nx\n4294967296\n");
                end
                send_queue(1'b0);
            end
            default:
            begin
                push_text("\n");
                send_queue(1'b0);
            end
        endcase
    endtask

    initial
    begin : result_sink
        results.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (!quiet && stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                results.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            results.ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (chars.valid && chars.ready) || (results.valid && results.ready))
            begin
                idle = 0;
            end
            else
            begin
                idle++;
            end
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : stimulus
        rst_n                <= 1'b0;
        chars.valid          <= 1'b0;
        chars.ch             <= '0;
        chars.end_of_archive <= 1'b0;
        n_sent    = 0;
        gap_pct   = 20;
        stall_pct = 20;
        quiet     = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_text("7777\n\n0\n0\n");
        arch_q.push_back(8'h00);
        arch_q.push_back(8'hFF);
        push_text(".a.\n2\n\naF\nb9\n");
        send_queue(1'b1);
        drain();

        while (n_sent < RANDOM_ITEMS - TAIL_ITEMS)
        begin
            case ($urandom_range(0, 2))
                0: gap_pct = 0;
                1: gap_pct = 15;
                default: gap_pct = 40;
            endcase
            case ($urandom_range(0, 2))
                0: stall_pct = 0;
                1: stall_pct = 15;
                default: stall_pct = 40;
            endcase
            add_archive();
            send_queue(1'b1);
            if ($urandom_range(0, 3) == 0)
            begin
                drain();
            end
        end

        quiet = 1'b1;
        add_archive();
        send_queue(1'b1);
        send_broken_record();
        repeat (6) send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (errors == 0 && outstanding == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
